FILE: rtl/tspbb_pkg.sv
// ----------------------------------------------------------------------------
// TSP branch and bound package
// Shared constants, types and command/status structs for the search core.
// ----------------------------------------------------------------------------
package tspbb_pkg;

  localparam int MaxNodes   = 16;
  localparam int NodeBits   = 4;
  localparam int CountBits  = 5;
  localparam int WeightBits = 16;
  localparam int CostBits   = 20;
  localparam int BestBits   = 21;
  localparam int CellBits   = 2 * NodeBits;
  localparam int EdgeBits   = WeightBits + 1;

  localparam logic [CostBits-1:0] CostCap  = {CostBits{1'b1}};
  localparam logic [BestBits-1:0] BestNone = {BestBits{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_EVAL,
    ST_EMIT,
    ST_NONE
  } state_t;

  typedef struct packed {
    logic start;
    logic fetch;
    logic eval;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic found;
    logic emit_last;
  } status_t;

endpackage

FILE: rtl/tspbb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module tspbb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tspbb_ctrl.sv
// ----------------------------------------------------------------------------
// TSP branch and bound controller
// Sequences load, search (fetch/evaluate per step) and result emission.
// ----------------------------------------------------------------------------
module tspbb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_cell,
  input  logic              out_ready,
  input  tspbb_pkg::status_t status,
  output tspbb_pkg::cmd_t    cmd,
  output logic              in_ready,
  output logic              out_valid,
  output logic              out_none
);
  import tspbb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid && last_cell) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_EVAL;
      ST_EVAL: begin
        if (status.done) state_next = status.found ? ST_EMIT : ST_NONE;
        else state_next = ST_FETCH;
      end
      ST_EMIT: begin
        if (out_ready && status.emit_last) state_next = ST_LOAD;
      end
      ST_NONE: begin
        if (out_ready) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_none  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready  = 1'b1;
        cmd.start = in_valid && last_cell;
      end
      ST_FETCH: cmd.fetch = 1'b1;
      ST_EVAL:  cmd.eval  = 1'b1;
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_next = out_ready;
      end
      ST_NONE: begin
        out_valid = 1'b1;
        out_none  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/tspbb_dp.sv
// ----------------------------------------------------------------------------
// TSP branch and bound datapath
// Edge RAM, search stacks, visited mask, best tour and result fields.
// ----------------------------------------------------------------------------
module tspbb_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cell_we,
  input  logic [tspbb_pkg::NodeBits-1:0]    row,
  input  logic [tspbb_pkg::NodeBits-1:0]    col,
  input  logic [tspbb_pkg::WeightBits-1:0]  weight,
  input  logic                              no_edge,
  input  logic                              cfg_we,
  input  logic [tspbb_pkg::CountBits-1:0]   cfg_data,
  input  tspbb_pkg::cmd_t                   cmd,
  input  logic                              out_none,
  output tspbb_pkg::status_t                status,
  output logic [tspbb_pkg::NodeBits-1:0]    position,
  output logic [tspbb_pkg::NodeBits-1:0]    node,
  output logic [tspbb_pkg::CostBits-1:0]    tour_cost,
  output logic                              tour_found,
  output logic                              last
);
  import tspbb_pkg::*;

  logic [CountBits-1:0]  node_count;
  logic [CountBits-1:0]  n_use;
  logic [NodeBits-1:0]   path   [MaxNodes];
  logic [CountBits-1:0]  cand   [MaxNodes];
  logic [CostBits-1:0]   pcost  [MaxNodes];
  logic [NodeBits-1:0]   best_path [MaxNodes];
  logic [MaxNodes-1:0]   visited;
  logic [NodeBits-1:0]   depth;
  logic [BestBits-1:0]   best_cost;
  logic [NodeBits-1:0]   emit_pos;
  logic [CellBits-1:0]   raddr;
  logic [EdgeBits-1:0]   rdata;
  logic [NodeBits-1:0]   u;
  logic [CountBits-1:0]  c;
  logic                  at_leaf;
  logic [CostBits:0]     sum;
  logic [CostBits-1:0]   sat;
  logic                  absent;
  logic                  back;

  tspbb_ram #(.Width(EdgeBits), .Depth(MaxNodes * MaxNodes)) u_edge (
    .clk   (clk),
    .we    (cell_we),
    .waddr ({row, col}),
    .wdata ({no_edge, weight}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (node_count < CountBits'(2)) n_use = CountBits'(2);
    else if (node_count > CountBits'(MaxNodes)) n_use = CountBits'(MaxNodes);
    else n_use = node_count;
  end

  assign u       = path[depth];
  assign c       = cand[depth];
  assign at_leaf = {1'b0, depth} == n_use - CountBits'(1);
  assign raddr   = at_leaf ? {u, {NodeBits{1'b0}}} : {u, c[NodeBits-1:0]};
  assign absent  = rdata[EdgeBits-1];
  assign sum     = {1'b0, pcost[depth]} + (CostBits+1)'(rdata[WeightBits-1:0]);
  assign sat     = sum[CostBits] ? CostCap : sum[CostBits-1:0];
  assign back    = at_leaf || (c >= n_use);

  assign status.done      = cmd.eval && back && (depth == '0);
  assign status.found     = best_cost != BestNone;
  assign status.emit_last = {1'b0, emit_pos} == n_use - CountBits'(1);

  assign position   = out_none ? '0 : emit_pos;
  assign node       = out_none ? '0 : best_path[emit_pos];
  assign tour_cost  = out_none ? '0 : best_cost[CostBits-1:0];
  assign tour_found = !out_none;
  assign last       = out_none || status.emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CountBits'(4);
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      visited   <= '0;
      best_cost <= BestNone;
      emit_pos  <= '0;
    end else if (cmd.start) begin
      depth     <= '0;
      visited   <= MaxNodes'(1);
      best_cost <= BestNone;
      emit_pos  <= '0;
      path[0]   <= '0;
      pcost[0]  <= '0;
      cand[0]   <= CountBits'(1);
    end else if (cmd.eval) begin
      if (at_leaf) begin
        if (!absent && {1'b0, sat} < best_cost) begin
          best_cost <= {1'b0, sat};
          for (int i = 0; i < MaxNodes; i++) begin
            best_path[i] <= path[i];
          end
        end
      end else if (!back) begin
        cand[depth] <= c + CountBits'(1);
        if (!visited[c[NodeBits-1:0]] && !absent && {1'b0, sat} < best_cost) begin
          depth                          <= depth + NodeBits'(1);
          path[depth + NodeBits'(1)]     <= c[NodeBits-1:0];
          pcost[depth + NodeBits'(1)]    <= sat;
          cand[depth + NodeBits'(1)]     <= CountBits'(1);
          visited[c[NodeBits-1:0]]       <= 1'b1;
        end
      end
      if (back && depth != '0) begin
        visited[u] <= 1'b0;
        depth      <= depth - NodeBits'(1);
      end
    end else if (cmd.emit_next) begin
      emit_pos <= emit_pos + NodeBits'(1);
    end
  end

endmodule

FILE: rtl/tsp_branch_and_bound_core.sv
// ----------------------------------------------------------------------------
// TSP branch and bound core
// Exact depth-first search for the lexicographically first minimum-cost tour.
// ----------------------------------------------------------------------------
// Loading: one matrix cell per cycle while in_ready. Search: each step is an
// edge RAM read, then an evaluate; run time follows tree size. Results: one
// per cycle while out_ready; node_count (clamped 2..16) transactions, one if
// no tour exists. Reset: synchronous; node_count goes to 4, RAM keeps its data.
module tsp_branch_and_bound_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tspbb_pkg::CountBits-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tspbb_pkg::NodeBits-1:0]    row,
  input  logic [tspbb_pkg::NodeBits-1:0]    col,
  input  logic [tspbb_pkg::WeightBits-1:0]  weight,
  input  logic                              no_edge,
  input  logic                              last_cell,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tspbb_pkg::NodeBits-1:0]    position,
  output logic [tspbb_pkg::NodeBits-1:0]    node,
  output logic [tspbb_pkg::CostBits-1:0]    tour_cost,
  output logic                              tour_found,
  output logic                              last
);
  import tspbb_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    out_none;

  tspbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_cell (last_cell),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_none  (out_none)
  );

  tspbb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cell_we    (in_valid && in_ready),
    .row        (row),
    .col        (col),
    .weight     (weight),
    .no_edge    (no_edge),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .out_none   (out_none),
    .status     (status),
    .position   (position),
    .node       (node),
    .tour_cost  (tour_cost),
    .tour_found (tour_found),
    .last       (last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken during output");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !out_valid) else $error("output right after start");

  a_found_cost: assert property (@(posedge clk) disable iff (rst)
    out_valid && tour_found |-> status.found) else $error("found without best");

endmodule
